// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, included by the top level
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge, off during reset
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mmpl_pkg.sv =====
// shared types, constants and operation codes for the mono mix peak level gate
// no dependencies
package mmpl_pkg;

  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned NUM_CH_MAX       = 8;
  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned CH_IDX_W         = 3;
  localparam int unsigned PEAK_W           = 15;
  localparam int unsigned QUIET_W          = 16;
  localparam int unsigned ALU_W            = 32;
  localparam int unsigned PROD_W           = 31;
  localparam int unsigned WEIGHT_W         = 16;
  localparam int unsigned OP_W             = 4;
  localparam int unsigned ADDR_W           = 3;
  localparam int unsigned DATA_W           = 32;

  localparam logic [PEAK_W-1:0]   PEAK_MAX  = 15'h7fff;
  localparam logic [WEIGHT_W-1:0] W_OLD     = 16'd52429;
  localparam logic [WEIGHT_W-1:0] W_NEW     = 16'd13107;
  localparam logic [PEAK_W-1:0]   THR_RESET = 15'd328;
  localparam logic [QUIET_W-1:0]  LIM_RESET = 16'd50;

  // register index, taken from paddr[2]
  localparam logic REG_VOICE_THR     = 1'b0;
  localparam logic REG_SILENCE_LIMIT = 1'b1;

  // datapath operations issued by the sequencer
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
  localparam logic [OP_W-1:0] OP_ACC  = 4'd2;
  localparam logic [OP_W-1:0] OP_ABS  = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd4;
  localparam logic [OP_W-1:0] OP_SIGN = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL0 = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL1 = 4'd7;
  localparam logic [OP_W-1:0] OP_OUT  = 4'd8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ch0_sample;
    logic signed [SAMPLE_W-1:0] ch1_sample;
    logic signed [SAMPLE_W-1:0] ch2_sample;
    logic signed [SAMPLE_W-1:0] ch3_sample;
    logic signed [SAMPLE_W-1:0] ch4_sample;
    logic signed [SAMPLE_W-1:0] ch5_sample;
    logic signed [SAMPLE_W-1:0] ch6_sample;
    logic signed [SAMPLE_W-1:0] ch7_sample;
    logic [NUM_CH_MAX-1:0]      channel_present;
    logic                       block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono_out;
    logic                       block_done;
    logic [PEAK_W-1:0]          block_peak;
    logic [PEAK_W-1:0]          smoothed_level;
    logic                       voice_gate;
  } out_item_t;

  typedef struct packed {
    logic [PEAK_W-1:0]  voice_thr;
    logic [QUIET_W-1:0] silence_limit;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CH_IDX_W-1:0] ch;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic peak_take;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/mono_mix_peak_level_vad_gate_unit.sv =====
// top level: config registers, sequencer and datapath of the mono mix peak level gate
// depends on mmpl_pkg, mmpl_seq, mmpl_dp and assert_macros.svh
//
//   channel   signals                                   direction
//   in        in_valid_i / in_ready_o / in_data_i       frame request in
//   out       out_valid_o / out_ready_i / out_data_o    result request out
//   cfg       psel penable pwrite paddr pwdata prdata   register access
//
// a frame runs through accumulate, absolute value, divide, sign and output steps, with
// the level steps added on a block end; no new frame is taken until it leaves the last step
// the divide of the channel sum by the present count is bit-serial
// the result waits in an output register, the next frame is taken meanwhile
// a full output register holds the sequencer in its last step
// reset clears the block state and loads the register defaults
`include "assert_macros.svh"

module mono_mix_peak_level_vad_gate_unit import mmpl_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [PEAK_W-1:0]  thr_q;
  logic [QUIET_W-1:0] lim_q;
  logic               cfg_wr;
  cfg_t               cfg;
  ctrl_t              ctrl;
  status_t            status;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      lim_q <= LIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_VOICE_THR:     thr_q <= pwdata[PEAK_W-1:0];
        REG_SILENCE_LIMIT: lim_q <= pwdata[QUIET_W-1:0];
        default: thr_q <= thr_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VOICE_THR:     prdata = DATA_W'(thr_q);
      REG_SILENCE_LIMIT: prdata = DATA_W'(lim_q);
      default: prdata = '0;
    endcase
  end

  assign cfg.voice_thr     = thr_q;
  assign cfg.silence_limit = lim_q;

  mmpl_seq #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .ctrl_o    (ctrl)
  );

  mmpl_dp #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `CHK_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted while busy")
  `CHK_SAME(a_peak_only_at_end, out_valid_o && !out_data_o.block_done,
            out_data_o.block_peak == '0, "peak shown on a frame inside a block")
  `CHK_SAME(a_gate_opens_on_voice,
            out_valid_o && out_data_o.block_done && (out_data_o.block_peak > thr_q),
            out_data_o.voice_gate, "gate closed after a loud block")

endmodule

// ===== hw/rtl/mmpl_seq.sv =====
// sequencer: walks one frame through accumulate, absolute value, divide, sign, level (on a block end) and output steps
// depends on mmpl_pkg
module mmpl_seq import mmpl_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(NUM_CHANNELS);
  localparam int unsigned STEP_W = $clog2(SUM_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SIGN = 3'd4;
  localparam logic [2:0] S_MUL0 = 3'd5;
  localparam logic [2:0] S_MUL1 = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic [STEP_W-1:0]   step_q, step_d;

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    step_d     = step_q;
    ctrl_o.op  = OP_NONE;
    ctrl_o.ch  = ch_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = OP_LOAD;
          ch_d      = '0;
          state_d   = S_ACC;
        end
      end
      S_ACC: begin
        ctrl_o.op = OP_ACC;
        if (ch_q == CH_IDX_W'(NUM_CHANNELS - 1)) begin
          state_d = S_ABS;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      S_ABS: begin
        ctrl_o.op = OP_ABS;
        step_d    = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        // one quotient bit per cycle
        ctrl_o.op = OP_DIV;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = S_SIGN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SIGN: begin
        ctrl_o.op = OP_SIGN;
        state_d   = status_i.last ? S_MUL0 : S_DONE;
      end
      S_MUL0: begin
        ctrl_o.op = OP_MUL0;
        state_d   = status_i.peak_take ? S_DONE : S_MUL1;
      end
      S_MUL1: begin
        ctrl_o.op = OP_MUL1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          ctrl_o.op = OP_OUT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== hw/rtl/mmpl_dp.sv =====
// datapath: shared adder and multiplier, block state and output register
// depends on mmpl_pkg, driven by mmpl_seq
module mmpl_dp import mmpl_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  ctrl_t     ctrl_i,
  input  cfg_t      cfg_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(NUM_CHANNELS);
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);

  in_item_t           in_q;
  logic [ALU_W-1:0]   acc_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   rem_q;
  logic               neg_q;
  logic [SAMPLE_W-1:0] mono_q;
  logic [PEAK_W-1:0]  running_peak_q;
  logic [PEAK_W-1:0]  level_q;
  logic [QUIET_W-1:0] quiet_q;
  logic               gate_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [SAMPLE_W-1:0] smp [NUM_CH_MAX];
  logic [SAMPLE_W-1:0] cur;
  logic                take;
  logic [CNT_W:0]      shifted;
  logic [PEAK_W-1:0]   mul_a;
  logic [WEIGHT_W-1:0] mul_b;
  logic [PROD_W-1:0]   prod;
  logic [ALU_W-1:0]    add_a, add_b, add_res;
  logic                add_sub;
  logic                qbit;
  logic [PEAK_W-1:0]   mag;
  logic [PEAK_W-1:0]   new_peak;
  logic [QUIET_W-1:0]  quiet_inc;
  logic                peak_take;
  logic                out_free;

  assign smp[0] = in_q.ch0_sample;
  assign smp[1] = in_q.ch1_sample;
  assign smp[2] = in_q.ch2_sample;
  assign smp[3] = in_q.ch3_sample;
  assign smp[4] = in_q.ch4_sample;
  assign smp[5] = in_q.ch5_sample;
  assign smp[6] = in_q.ch6_sample;
  assign smp[7] = in_q.ch7_sample;

  assign cur     = smp[ctrl_i.ch];
  assign take    = in_q.channel_present[ctrl_i.ch];
  assign shifted = {rem_q, acc_q[SUM_W-1]};

  // one multiplier, old level by 0.8 then peak by 0.2
  assign mul_a = (ctrl_i.op == OP_MUL1) ? running_peak_q : level_q;
  assign mul_b = (ctrl_i.op == OP_MUL1) ? W_NEW : W_OLD;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ctrl_i.op)
      OP_ACC: begin
        add_a = acc_q;
        add_b = {{(ALU_W - SAMPLE_W){cur[SAMPLE_W-1]}}, cur};
      end
      OP_ABS: begin
        add_sub = acc_q[ALU_W-1];
        add_a   = acc_q[ALU_W-1] ? '0 : acc_q;
        add_b   = acc_q[ALU_W-1] ? acc_q : '0;
      end
      OP_DIV: begin
        add_a   = ALU_W'(shifted);
        add_b   = ALU_W'(cnt_q);
        add_sub = 1'b1;
      end
      OP_SIGN: begin
        add_b   = acc_q;
        add_sub = 1'b1;
      end
      OP_MUL0: begin
        add_b = ALU_W'(prod);
      end
      OP_MUL1: begin
        add_a = acc_q;
        add_b = ALU_W'(prod);
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_res = add_a + (add_sub ? ~add_b : add_b) + ALU_W'(add_sub);
  assign qbit    = ~add_res[ALU_W-1];

  // quotient magnitude can reach 32768, clip to the peak range
  always_comb begin
    if (cnt_q == '0) begin
      mag = '0;
    end else if (acc_q > ALU_W'(PEAK_MAX)) begin
      mag = PEAK_MAX;
    end else begin
      mag = acc_q[PEAK_W-1:0];
    end
  end

  assign new_peak  = (mag > running_peak_q) ? mag : running_peak_q;
  assign quiet_inc = (quiet_q == '1) ? quiet_q : quiet_q + 1'b1;
  assign peak_take = running_peak_q > level_q;
  assign out_free  = ~out_valid_q | out_ready_i;

  assign status_o.last      = in_q.block_end;
  assign status_o.peak_take = peak_take;
  assign status_o.out_free  = out_free;

  // working registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        in_q  <= in_data_i;
        acc_q <= '0;
        cnt_q <= '0;
      end
      OP_ACC: begin
        if (take) begin
          acc_q <= add_res;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      OP_ABS: begin
        acc_q <= add_res;
        neg_q <= acc_q[ALU_W-1];
        rem_q <= '0;
      end
      OP_DIV: begin
        rem_q <= qbit ? add_res[CNT_W-1:0] : shifted[CNT_W-1:0];
        acc_q <= ALU_W'({acc_q[SUM_W-2:0], qbit});
      end
      OP_SIGN: begin
        if (cnt_q == '0) begin
          mono_q <= '0;
        end else begin
          mono_q <= neg_q ? add_res[SAMPLE_W-1:0] : acc_q[SAMPLE_W-1:0];
        end
      end
      OP_MUL0: begin
        acc_q <= add_res;
      end
      OP_OUT: begin
        out_q.mono_out       <= mono_q;
        out_q.block_done     <= in_q.block_end;
        out_q.block_peak     <= in_q.block_end ? running_peak_q : '0;
        out_q.smoothed_level <= level_q;
        out_q.voice_gate     <= gate_q;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_peak_q <= '0;
      level_q        <= '0;
      quiet_q        <= '0;
      gate_q         <= 1'b0;
    end else begin
      case (ctrl_i.op)
        OP_SIGN: begin
          running_peak_q <= new_peak;
        end
        OP_MUL0: begin
          if (peak_take) begin
            level_q <= running_peak_q;
          end
          if (running_peak_q > cfg_i.voice_thr) begin
            quiet_q <= '0;
            gate_q  <= 1'b1;
          end else begin
            quiet_q <= quiet_inc;
            if (quiet_inc > cfg_i.silence_limit) begin
              gate_q <= 1'b0;
            end
          end
        end
        OP_MUL1: begin
          level_q <= add_res[PROD_W-1:PROD_W-PEAK_W];
        end
        OP_OUT: begin
          if (in_q.block_end) begin
            running_peak_q <= '0;
          end
        end
        default: begin
          gate_q <= gate_q;
        end
      endcase
    end
  end

  // output valid: a new result replaces one taken in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
